FILE: rtl/slt_pkg.sv
package slt_pkg;

    localparam int KEY_W   = 16;
    localparam int PAY_W   = 16;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 9;

    // operation codes
    typedef enum logic [2:0] {
        KIND_INSERT  = 3'd0,
        KIND_REPLACE = 3'd1,
        KIND_SEEK    = 3'd2,
        KIND_LOOKUP  = 3'd3,
        KIND_CLEAR   = 3'd4
    } kind_t;

    // result codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EXISTS  = 2'd1,
        STATUS_MISSING = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [KEY_W-1:0] line_key;
        logic [PAY_W-1:0] payload_in;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [POS_W-1:0]   position;
        logic [KEY_W-1:0]   found_key;
        logic [PAY_W-1:0]   payload_out;
        logic [COUNT_W-1:0] entry_count;
    } out_beat_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic  apply;
        kind_t kind;
        logic  hit;
    } cell_ctrl_t;

endpackage

FILE: rtl/slt_cell.sv
module slt_cell
    import slt_pkg::*;
#(
    parameter int HW = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] op_key,
    input  logic [HW-1:0]    op_pay,
    input  logic [KEY_W-1:0] left_key,
    input  logic [HW-1:0]    left_pay,
    input  logic             left_valid,
    input  logic             left_ge,
    output logic [KEY_W-1:0] key_out,
    output logic [HW-1:0]    pay_out,
    output logic             valid_out,
    output logic             ge_out,
    output logic             sel_out
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [HW-1:0]    pay_reg, pay_next;
    logic             valid_reg, valid_next;
    logic             ge;
    logic             sel;
    logic             first_empty;

    // compare against the broadcast key
    assign ge          = valid_reg && (key_reg >= op_key);
    assign sel         = ge && !left_ge;
    assign first_empty = !valid_reg && left_valid;

    // shift, load, replace payload or clear
    always_comb begin
        key_next   = key_reg;
        pay_next   = pay_reg;
        valid_next = valid_reg;
        if (ctrl.apply) begin
            case (ctrl.kind)
                KIND_INSERT: begin
                    if (sel) begin
                        key_next = op_key;
                        pay_next = op_pay;
                    end else if (ge) begin
                        key_next = left_key;
                        pay_next = left_pay;
                    end else if (first_empty) begin
                        valid_next = 1'b1;
                        if (ctrl.hit) begin
                            key_next = left_key;
                            pay_next = left_pay;
                        end else begin
                            key_next = op_key;
                            pay_next = op_pay;
                        end
                    end
                end
                KIND_REPLACE: begin
                    if (sel) begin
                        pay_next = op_pay;
                    end
                end
                KIND_CLEAR: begin
                    valid_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign key_out   = key_reg;
    assign pay_out   = pay_reg;
    assign valid_out = valid_reg;
    assign ge_out    = ge;
    assign sel_out   = sel;

endmodule

FILE: rtl/slt_tree.sv
module slt_tree
    import slt_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int HW    = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [DEPTH-1:0]                 sel,
    input  logic [DEPTH-1:0][KEY_W-1:0]      keys,
    input  logic [DEPTH-1:0][HW-1:0]         pays,
    output logic                             root_hit,
    output logic [$clog2(DEPTH)-1:0]         root_idx,
    output logic [KEY_W-1:0]                 root_key,
    output logic [HW-1:0]                    root_pay
);

    localparam int LEVELS = $clog2(DEPTH);
    localparam int LEAVES = 2 ** LEVELS;
    localparam int IW     = LEVELS;

    // heap-ordered nodes: root at 1, leaves from LEAVES upward
    logic          node_hit_reg [1:2*LEAVES-1];
    logic [IW-1:0] node_idx_reg [1:2*LEAVES-1];
    logic [KEY_W-1:0] node_key_reg [1:2*LEAVES-1];
    logic [HW-1:0] node_pay_reg [1:2*LEAVES-1];

    genvar n;
    generate
        for (n = 1; n < 2 * LEAVES; n++) begin : g_node
            if (n >= LEAVES) begin : g_leaf
                if (n - LEAVES < DEPTH) begin : g_used
                    // one-hot select masks the leaf data so parents can OR
                    always_ff @(posedge aclk) begin
                        if (!aresetn) begin
                            node_hit_reg[n] <= 1'b0;
                        end else begin
                            node_hit_reg[n] <= sel[n-LEAVES];
                        end
                    end
                    always_ff @(posedge aclk) begin
                        node_idx_reg[n] <= sel[n-LEAVES] ? IW'(n - LEAVES) : '0;
                        node_key_reg[n] <= sel[n-LEAVES] ? keys[n-LEAVES] : '0;
                        node_pay_reg[n] <= sel[n-LEAVES] ? pays[n-LEAVES] : '0;
                    end
                end else begin : g_pad
                    always_ff @(posedge aclk) begin
                        node_hit_reg[n] <= 1'b0;
                        node_idx_reg[n] <= '0;
                        node_key_reg[n] <= '0;
                        node_pay_reg[n] <= '0;
                    end
                end
            end else begin : g_inner
                // combine two children, one register per level
                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        node_hit_reg[n] <= 1'b0;
                    end else begin
                        node_hit_reg[n] <= node_hit_reg[2*n] | node_hit_reg[2*n+1];
                    end
                end
                always_ff @(posedge aclk) begin
                    node_idx_reg[n] <= node_idx_reg[2*n] | node_idx_reg[2*n+1];
                    node_key_reg[n] <= node_key_reg[2*n] | node_key_reg[2*n+1];
                    node_pay_reg[n] <= node_pay_reg[2*n] | node_pay_reg[2*n+1];
                end
            end
        end
    endgenerate

    assign root_hit = node_hit_reg[1];
    assign root_idx = node_idx_reg[1];
    assign root_key = node_key_reg[1];
    assign root_pay = node_pay_reg[1];

endmodule

FILE: rtl/sorted_line_table_core.sv
// One operation at a time: a new input beat is taken only when idle, after the previous
// result has been registered. The sequencer waits meanwhile for the registered
// select tree that brings the matching cell's index, key and payload to the root.
// Cells compare in parallel and shift or load in the single cycle the result is taken.
// Reset (aresetn low, synchronous) empties the table and clears all control state;
// stored keys and payloads are left as they are and are never read until rewritten.
module sorted_line_table_core
    import slt_pkg::*;
#(
    parameter int DEPTH        = 256,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_beat,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_beat
);

    localparam int HW     = HANDLE_WIDTH;
    localparam int LEVELS = $clog2(DEPTH);
    localparam int IW     = LEVELS;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int WAIT_CYCLES = LEVELS + 1;
    localparam int TW     = $clog2(WAIT_CYCLES + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WAIT = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [TW-1:0]   wait_reg, wait_next;
    in_beat_t        op_reg;
    logic [CW-1:0]   count_reg, count_next;
    out_beat_t       out_reg, out_next;
    logic            m_valid_reg, m_valid_next;

    logic [KEY_W-1:0] op_key;
    logic [HW-1:0]    op_pay;
    cell_ctrl_t       ctrl;

    logic [DEPTH-1:0]            cell_valid;
    logic [DEPTH-1:0]            cell_ge;
    logic [DEPTH-1:0]            cell_sel;
    logic [DEPTH-1:0][KEY_W-1:0] cell_key;
    logic [DEPTH-1:0][HW-1:0]    cell_pay;

    logic             root_hit;
    logic [IW-1:0]    root_idx;
    logic [KEY_W-1:0] root_key;
    logic [HW-1:0]    root_pay;

    logic in_fire;
    logic done;
    logic out_free;
    logic finish;
    logic eq;
    logic apply;

    assign op_key = op_reg.line_key;
    assign op_pay = HW'(op_reg.payload_in);

    // row of cells, each but the first fed by its left neighbor
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            if (i == 0) begin : g_head
                slt_cell #(.HW(HW)) u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .ctrl       (ctrl),
                    .op_key     (op_key),
                    .op_pay     (op_pay),
                    .left_key   ('0),
                    .left_pay   ('0),
                    .left_valid (1'b1),
                    .left_ge    (1'b0),
                    .key_out    (cell_key[i]),
                    .pay_out    (cell_pay[i]),
                    .valid_out  (cell_valid[i]),
                    .ge_out     (cell_ge[i]),
                    .sel_out    (cell_sel[i])
                );
            end else begin : g_body
                slt_cell #(.HW(HW)) u_cell (
                    .aclk       (aclk),
                    .aresetn    (aresetn),
                    .ctrl       (ctrl),
                    .op_key     (op_key),
                    .op_pay     (op_pay),
                    .left_key   (cell_key[i-1]),
                    .left_pay   (cell_pay[i-1]),
                    .left_valid (cell_valid[i-1]),
                    .left_ge    (cell_ge[i-1]),
                    .key_out    (cell_key[i]),
                    .pay_out    (cell_pay[i]),
                    .valid_out  (cell_valid[i]),
                    .ge_out     (cell_ge[i]),
                    .sel_out    (cell_sel[i])
                );
            end
        end
    endgenerate

    // gather the boundary cell
    slt_tree #(.DEPTH(DEPTH), .HW(HW)) u_tree (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sel      (cell_sel),
        .keys     (cell_key),
        .pays     (cell_pay),
        .root_hit (root_hit),
        .root_idx (root_idx),
        .root_key (root_key),
        .root_pay (root_pay)
    );

    // handshake
    assign s_ready  = (state_reg == S_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign done     = (state_reg == S_WAIT) && (wait_reg == TW'(WAIT_CYCLES));
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = done && out_free;
    assign eq       = root_hit && (root_key == op_key);

    // result and table update decision
    always_comb begin
        out_next     = '0;
        count_next   = count_reg;
        apply        = 1'b0;
        out_next.status = STATUS_OK;
        case (kind_t'(op_reg.kind))
            KIND_INSERT: begin
                if (eq) begin
                    out_next.status   = STATUS_EXISTS;
                    out_next.position = POS_W'(root_idx);
                end else if (count_reg == CW'(DEPTH)) begin
                    out_next.status = STATUS_FULL;
                end else begin
                    apply      = 1'b1;
                    count_next = count_reg + CW'(1);
                    out_next.position = root_hit ? POS_W'(root_idx) : POS_W'(count_reg);
                end
            end
            KIND_REPLACE: begin
                if (eq) begin
                    apply = 1'b1;
                    out_next.position = POS_W'(root_idx);
                end else begin
                    out_next.status = STATUS_MISSING;
                end
            end
            KIND_SEEK: begin
                if (root_hit) begin
                    out_next.position    = POS_W'(root_idx);
                    out_next.found_key   = root_key;
                    out_next.payload_out = PAY_W'(root_pay);
                end else begin
                    out_next.status = STATUS_MISSING;
                end
            end
            KIND_LOOKUP: begin
                if (eq) begin
                    out_next.position    = POS_W'(root_idx);
                    out_next.found_key   = root_key;
                    out_next.payload_out = PAY_W'(root_pay);
                end else begin
                    out_next.status = STATUS_MISSING;
                end
            end
            KIND_CLEAR: begin
                apply      = 1'b1;
                count_next = '0;
            end
            default: begin
            end
        endcase
        out_next.entry_count = COUNT_W'(count_next);
    end

    assign ctrl.apply = apply && finish;
    assign ctrl.kind  = kind_t'(op_reg.kind);
    assign ctrl.hit   = root_hit;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        wait_next    = wait_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = S_WAIT;
                    wait_next  = '0;
                end
            end
            S_WAIT: begin
                if (!done) begin
                    wait_next = wait_reg + TW'(1);
                end else if (out_free) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wait_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            m_valid_reg <= m_valid_next;
            if (finish) begin
                count_reg <= count_next;
            end
        end
    end

    // beat payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg <= s_beat;
        end
        if (finish) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = out_reg;

    // fill count never passes the table size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("fill count above table size");

    // valid cells form a prefix whose length is the fill count
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(cell_valid) == CW'(count_reg)) &&
        ((cell_valid & (cell_valid + DEPTH'(1))) == '0))
        else $error("valid cells do not match fill count");

    // a selected cell lies inside the filled part
    a_root_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (done && root_hit) |-> (CW'(root_idx) < count_reg))
        else $error("tree hit beyond fill count");

    // clear empties the table
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.apply && ctrl.kind == KIND_CLEAR) |=> (cell_valid == '0))
        else $error("clear left valid cells");

    // at most one boundary cell
    a_sel_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_sel))
        else $error("more than one boundary cell");

endmodule
